// File: rtl/core/rsb_pkg.sv
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared types and constants of the RLE sprite blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsb_pkg;

    localparam int FRAME_BYTES_DEF = 65536;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [1:0] MODE_STREAM = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] DRAW_SHADOW = 2'd1;
    localparam logic [1:0] DRAW_MONO   = 2'd2;

    localparam logic [2:0] REG_POS_X       = 3'd0;
    localparam logic [2:0] REG_POS_Y       = 3'd1;
    localparam logic [2:0] REG_SURF_WIDTH  = 3'd2;
    localparam logic [2:0] REG_SURF_HEIGHT = 3'd3;
    localparam logic [2:0] REG_ROW_PITCH   = 3'd4;
    localparam logic [2:0] REG_DRAW_MODE   = 3'd5;
    localparam logic [2:0] REG_COLOR_SHIFT = 3'd6;
    localparam logic [2:0] REG_MONO_COLOR  = 3'd7;

    localparam logic [11:0] SURF_WIDTH_RST  = 12'd320;
    localparam logic [11:0] SURF_HEIGHT_RST = 12'd200;
    localparam logic [11:0] ROW_PITCH_RST   = 12'd320;

    localparam logic [7:0]  SKIP_BASE    = 8'h80;
    localparam logic [31:0] HEADER_MAGIC = 32'h0000_0002;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [11:0]        surf_width;
        logic [11:0]        surf_height;
        logic [11:0]        row_pitch;
        logic [1:0]         draw_mode;
        logic signed [4:0]  color_shift;
        logic [7:0]         mono_color;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ,
        OP_DRAW,
        OP_SHADE
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [15:0] address;
        logic [11:0] sx;
        logic [11:0] sy;
        logic [7:0]  value;
        logic        done;
        logic        in_bitmap;
    } op_t;

endpackage

`default_nettype wire

// File: rtl/core/rsb_ram.sv
// ----------------------------------------------------------------------------
// rsb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/rsb_front.sv
// ----------------------------------------------------------------------------
// rsb_front
// Stream parser: decodes header, skip and literal codes, clips pixels, passes
// direct writes and reads, and emits one store operation per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_front
    import rsb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        take,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  data,
    input  wire logic [15:0] address,
    output op_t              op
);

    typedef enum logic [1:0] {
        PH_HDR,
        PH_CODE,
        PH_LIT
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [31:0]        hbytes_reg, hbytes_next;
    logic [3:0]         hcount_reg, hcount_next;
    logic [15:0]        width_reg, width_next;
    logic [15:0]        height_reg, height_next;
    logic [15:0]        col_reg, col_next;
    logic [16:0]        row_reg, row_next;
    logic [7:0]         run_reg, run_next;
    logic signed [33:0] rem_reg, rem_next;

    logic signed [17:0] sx;
    logic signed [18:0] sy;
    logic               visible;
    logic signed [5:0]  low_sum;
    logic [3:0]         low_clamp;
    logic [3:0]         high_nib;
    logic [6:0]         adv_n;
    logic               adv_en;
    logic               check;
    logic [16:0]        col_sum;
    logic               done;

    always_comb begin
        phase_next  = phase_reg;
        hbytes_next = hbytes_reg;
        hcount_next = hcount_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        run_next    = run_reg;
        rem_next    = rem_reg;
        adv_n       = '0;
        adv_en      = 1'b0;
        check       = 1'b0;
        done        = 1'b0;
        col_sum     = '0;

        sx = cfg.pos_x + $signed({2'b00, col_reg});
        sy = cfg.pos_y + $signed({2'b00, row_reg});
        visible = !sx[17] && (sx[16:12] == '0) && (sx[11:0] < cfg.surf_width) &&
                  !sy[18] && (sy[17:12] == '0) && (sy[11:0] < cfg.surf_height);
        low_sum = $signed({2'b00, data[3:0]}) + 6'(cfg.color_shift);
        if (low_sum[5]) begin
            low_clamp = 4'd0;
        end else if (low_sum[4]) begin
            low_clamp = 4'd15;
        end else begin
            low_clamp = low_sum[3:0];
        end
        high_nib = (cfg.draw_mode == DRAW_MONO) ? cfg.mono_color[7:4] : data[7:4];

        op.kind    = OP_NONE;
        op.address = address;
        op.sx      = sx[11:0];
        op.sy      = sy[11:0];
        op.value   = {high_nib, low_clamp};

        unique case (mode)
            MODE_STREAM: begin
                unique case (phase_reg)
                    PH_HDR: begin
                        hbytes_next = {data, hbytes_reg[31:8]};
                        hcount_next = hcount_reg + 4'd1;
                        if (hcount_next == 4'd4 && hbytes_next == HEADER_MAGIC) begin
                            hcount_next = hcount_reg + 4'd1;
                        end else if (hcount_next == 4'd4 || hcount_next == 4'd8) begin
                            width_next  = hbytes_next[15:0];
                            height_next = hbytes_next[31:16];
                            hcount_next = '0;
                            hbytes_next = '0;
                            col_next    = '0;
                            row_next    = '0;
                            run_next    = '0;
                            rem_next    = $signed({2'b00,
                                          {16'd0, width_next} * {16'd0, height_next}});
                            if (width_next == '0 || height_next == '0) begin
                                done = 1'b1;
                            end else begin
                                phase_next = PH_CODE;
                            end
                        end
                    end
                    PH_CODE: begin
                        if (data[7] && ({9'd0, data[6:0]} <= width_reg)) begin
                            adv_en = 1'b1;
                            adv_n  = data[6:0];
                            check  = 1'b1;
                        end else if (data != '0) begin
                            run_next   = data;
                            phase_next = PH_LIT;
                        end else begin
                            check = 1'b1;
                        end
                    end
                    PH_LIT: begin
                        if (visible) begin
                            op.kind = (cfg.draw_mode == DRAW_SHADOW) ? OP_SHADE : OP_DRAW;
                        end
                        adv_en   = 1'b1;
                        adv_n    = 7'd1;
                        run_next = run_reg - 8'd1;
                        if (run_reg == 8'd1) begin
                            phase_next = PH_CODE;
                            check      = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = PH_HDR;
                    end
                endcase
            end
            MODE_WRITE: begin
                op.kind  = OP_WRITE;
                op.value = data;
            end
            MODE_READ: begin
                op.kind = OP_READ;
            end
            default: begin
                op.kind = OP_NONE;
            end
        endcase

        if (adv_en) begin
            rem_next = rem_reg - $signed({27'd0, adv_n});
            col_sum  = {1'b0, col_reg} + {10'd0, adv_n};
            if (col_sum >= {1'b0, width_reg}) begin
                col_next = 16'(col_sum - {1'b0, width_reg});
                row_next = row_reg + 17'd1;
            end else begin
                col_next = col_sum[15:0];
            end
        end
        if (check && (rem_next[33] || rem_next == '0)) begin
            phase_next = PH_HDR;
            done       = 1'b1;
        end

        op.done      = done;
        op.in_bitmap = (phase_next != PH_HDR) || (hcount_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR;
            hbytes_reg <= '0;
            hcount_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            run_reg    <= '0;
            rem_reg    <= '0;
        end else if (take) begin
            phase_reg  <= phase_next;
            hbytes_reg <= hbytes_next;
            hcount_reg <= hcount_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            run_reg    <= run_next;
            rem_reg    <= rem_next;
        end
    end

`ifndef ASSERT_OFF
    a_lit_run: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LIT |-> run_reg != '0)
        else $error("literal phase with empty run");
    a_hdr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_HDR |-> hcount_reg == '0)
        else $error("header count left over in body");
    a_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_HDR |-> (width_reg != '0 && height_reg != '0))
        else $error("body parse with empty bitmap");
`endif

endmodule

`default_nettype wire

// File: rtl/core/rsb_queue.sv
// ----------------------------------------------------------------------------
// rsb_queue
// Short FIFO of store operations between the parser and the store pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_queue
    import rsb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire op_t  push_op,
    output logic      not_full,
    input  wire logic pop,
    output logic      not_empty,
    output op_t       head
);

    localparam int PW = $clog2(DEPTH);

    op_t          mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW:0]   count_reg, count_next;

    assign not_full  = count_reg != DEPTH[PW:0];
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_op;
        end
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rsb_back.sv
// ----------------------------------------------------------------------------
// rsb_back
// Store pipeline: address multiply, frame store read, write back with
// forwarding for shadow read-modify-write, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsb_back
    import rsb_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [11:0] row_pitch,
    input  wire logic        q_valid,
    input  wire op_t         q_op,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data,
    output logic             m_bitmap_done,
    output logic             m_in_bitmap
);

    localparam int AW = $clog2(FRAME_BYTES);

    logic          adv;
    logic          a_valid_reg, b_valid_reg, c_valid_reg;
    op_t           a_op_reg, b_op_reg, c_op_reg;
    logic [AW-1:0] b_addr_reg, c_addr_reg;
    logic [AW-1:0] a_addr;
    logic [24:0]   xy_addr;
    logic [AW+24:0] xy_ext;
    logic [AW+15:0] dir_ext;
    logic          fwd_valid_reg;
    logic [7:0]    fwd_data_reg;
    logic [7:0]    ram_rdata;
    logic [7:0]    old_data;
    logic          c_we;
    logic [7:0]    c_wdata;
    logic          m_valid_reg;
    logic [7:0]    rd_reg;
    logic          done_reg, inb_reg;

    assign adv   = !m_valid_reg || m_ready;
    assign q_pop = adv && q_valid;

    always_comb begin
        xy_addr = {1'b0, 24'(a_op_reg.sy) * 24'(row_pitch)} + {13'd0, a_op_reg.sx};
        xy_ext  = {{AW{1'b0}}, xy_addr};
        dir_ext = {{AW{1'b0}}, a_op_reg.address};
        if (a_op_reg.kind == OP_DRAW || a_op_reg.kind == OP_SHADE) begin
            a_addr = xy_ext[AW-1:0];
        end else begin
            a_addr = dir_ext[AW-1:0];
        end
    end

    always_comb begin
        old_data = fwd_valid_reg ? fwd_data_reg : ram_rdata;
        c_we     = 1'b0;
        c_wdata  = c_op_reg.value;
        if (c_valid_reg) begin
            unique case (c_op_reg.kind)
                OP_WRITE, OP_DRAW: begin
                    c_we = 1'b1;
                end
                OP_SHADE: begin
                    c_we    = 1'b1;
                    c_wdata = {old_data[7:4], 1'b0, old_data[3:1]};
                end
                default: begin
                    c_we = 1'b0;
                end
            endcase
        end
    end

    rsb_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (adv && c_we),
        .waddr (c_addr_reg),
        .wdata (c_wdata),
        .re    (adv),
        .raddr (b_addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_op_reg      <= q_op;
            b_op_reg      <= a_op_reg;
            b_addr_reg    <= a_addr;
            c_op_reg      <= b_op_reg;
            c_addr_reg    <= b_addr_reg;
            fwd_valid_reg <= c_we && (c_addr_reg == b_addr_reg);
            fwd_data_reg  <= c_wdata;
            rd_reg        <= (c_op_reg.kind == OP_READ) ? old_data : 8'd0;
            done_reg      <= c_op_reg.done;
            inb_reg       <= c_op_reg.in_bitmap;
        end
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= q_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= c_valid_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_data   = rd_reg;
    assign m_bitmap_done = done_reg;
    assign m_in_bitmap   = inb_reg;

endmodule

`default_nettype wire

// File: rtl/core/rle_sprite_blitter.sv
// Input transfers pass the operation queue, stages A, B, C and the result register.
// One item per cycle unless stalled; shadow read-modify-write forwards the prior write.
// The frame store pipeline stalls as a whole while a result waits on m_ready.
// Input ready drops only when the four-entry operation queue is full.
// Reset clears parse state, queue and pipeline; frame store contents stay unknown.
// ----------------------------------------------------------------------------
// rle_sprite_blitter
// RLE sprite decoder drawing into an internal 8-bit frame store.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_sprite_blitter
    import rsb_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_data,
    input  wire logic [15:0] s_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data,
    output logic             m_bitmap_done,
    output logic             m_in_bitmap
);

    cfg_t cfg_reg;
    op_t  front_op, head_op;
    logic take, q_has, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pos_x       <= '0;
            cfg_reg.pos_y       <= '0;
            cfg_reg.surf_width  <= SURF_WIDTH_RST;
            cfg_reg.surf_height <= SURF_HEIGHT_RST;
            cfg_reg.row_pitch   <= ROW_PITCH_RST;
            cfg_reg.draw_mode   <= '0;
            cfg_reg.color_shift <= '0;
            cfg_reg.mono_color  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_POS_X:       cfg_reg.pos_x       <= cfg_wdata;
                REG_POS_Y:       cfg_reg.pos_y       <= cfg_wdata;
                REG_SURF_WIDTH:  cfg_reg.surf_width  <= cfg_wdata[11:0];
                REG_SURF_HEIGHT: cfg_reg.surf_height <= cfg_wdata[11:0];
                REG_ROW_PITCH:   cfg_reg.row_pitch   <= cfg_wdata[11:0];
                REG_DRAW_MODE:   cfg_reg.draw_mode   <= cfg_wdata[1:0];
                REG_COLOR_SHIFT: cfg_reg.color_shift <= cfg_wdata[4:0];
                REG_MONO_COLOR:  cfg_reg.mono_color  <= cfg_wdata[7:0];
                default:         cfg_reg.mono_color  <= cfg_reg.mono_color;
            endcase
        end
    end

    assign take = s_valid && s_ready;

    rsb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .take    (take),
        .mode    (s_mode),
        .data    (s_data),
        .address (s_address),
        .op      (front_op)
    );

    rsb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (take),
        .push_op   (front_op),
        .not_full  (s_ready),
        .pop       (q_pop),
        .not_empty (q_has),
        .head      (head_op)
    );

    rsb_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .row_pitch     (cfg_reg.row_pitch),
        .q_valid       (q_has),
        .q_op          (head_op),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_bitmap_done (m_bitmap_done),
        .m_in_bitmap   (m_in_bitmap)
    );

endmodule

`default_nettype wire

// File: test/rle_sprite_blitter_tb.sv
// ----------------------------------------------------------------------------
// rle_sprite_blitter_tb
// Self-checking testbench: drives bitmap streams and direct frame store
// accesses through the valid/ready input channel, predicts every result
// with an internal decoder and frame store copy, and checks each result
// transfer field by field under random input gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rle_sprite_blitter_tb;
    import rsb_pkg::*;

    typedef struct {
        logic [7:0] read_data;
        logic       bitmap_done;
        logic       in_bitmap;
    } blit_result_t;

    localparam int IDLE_LIMIT = 5000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [7:0]  s_data;
    logic [15:0] s_address;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_read_data;
    logic        m_bitmap_done;
    logic        m_in_bitmap;

    rle_sprite_blitter uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_data       (s_data),
        .s_address    (s_address),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_bitmap_done(m_bitmap_done),
        .m_in_bitmap  (m_in_bitmap)
    );

    // predicted block state
    cfg_t              cfg;
    logic [7:0]        pixel_mem [FRAME_BYTES_DEF];
    bit                pixel_set [FRAME_BYTES_DEF];
    logic [15:0]       set_addrs [$];
    int unsigned       phase, hdr_word, hdr_count, bmp_w, bmp_h, col, row, run_left;
    longint unsigned   pixels_done;

    blit_result_t      pending_results [$];
    int                errors;
    int                items_sent;
    int                idle_cycles;
    int                stall_left;
    bit                burst;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void mark_written(logic [15:0] a, logic [7:0] v);
        if (!pixel_set[a]) set_addrs.push_back(a);
        pixel_set[a] = 1'b1;
        pixel_mem[a] = v;
    endfunction

    function automatic bit pixel_target(output logic [15:0] a);
        longint sx, sy;
        sx = longint'(cfg.pos_x) + col;
        sy = longint'(cfg.pos_y) + row;
        if (sx < 0 || sx >= cfg.surf_width || sy < 0 || sy >= cfg.surf_height)
            return 1'b0;
        a = 16'((sy * cfg.row_pitch + sx) % FRAME_BYTES_DEF);
        return 1'b1;
    endfunction

    function automatic void plot(logic [7:0] v);
        logic [15:0] a;
        int          lo;
        logic [7:0]  d;
        if (!pixel_target(a)) return;
        if (cfg.draw_mode == DRAW_SHADOW) begin
            d = pixel_mem[a];
            mark_written(a, {d[7:4], 1'b0, d[3:1]});
            return;
        end
        lo = int'(v[3:0]) + int'(cfg.color_shift);
        if (lo > 15) lo = 15;
        if (lo < 0) lo = 0;
        mark_written(a, {(cfg.draw_mode == DRAW_MONO) ? cfg.mono_color[7:4] : v[7:4],
                         4'(lo)});
    endfunction

    function automatic void step_pixels(int unsigned n);
        pixels_done += n;
        col += n;
        if (col >= bmp_w) begin
            col -= bmp_w;
            row = (row + 1) & 32'h1FFFF;
        end
    endfunction

    function automatic bit decode_byte(logic [7:0] b);
        if (phase == 0) begin
            hdr_word = (hdr_word >> 8) | (int'(b) << 24);
            hdr_count++;
            if (hdr_count == 4 && hdr_word == HEADER_MAGIC) return 1'b0;
            if (hdr_count != 4 && hdr_count != 8) return 1'b0;
            bmp_w = hdr_word & 32'hFFFF;
            bmp_h = hdr_word >> 16;
            hdr_count = 0;
            hdr_word = 0;
            col = 0;
            row = 0;
            run_left = 0;
            pixels_done = 0;
            if (bmp_w == 0 || bmp_h == 0) return 1'b1;
            phase = 1;
            return 1'b0;
        end
        if (phase == 1) begin
            if (b >= SKIP_BASE && int'(b) <= 128 + bmp_w) begin
                step_pixels(b - SKIP_BASE);
            end else if (b != 0) begin
                run_left = b;
                phase = 2;
                return 1'b0;
            end
        end else begin
            plot(b);
            step_pixels(1);
            run_left--;
            if (run_left != 0) return 1'b0;
            phase = 1;
        end
        if (pixels_done >= longint'(bmp_w) * bmp_h) begin
            phase = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic blit_result_t predict_blit(logic [1:0] md, logic [7:0] dt,
                                                  logic [15:0] ad);
        blit_result_t r;
        r.read_data = 8'h00;
        r.bitmap_done = 1'b0;
        case (md)
            MODE_STREAM: r.bitmap_done = decode_byte(dt);
            MODE_WRITE:  mark_written(ad, dt);
            MODE_READ:   r.read_data = pixel_mem[ad];
            default: ;
        endcase
        r.in_bitmap = (phase != 0 || hdr_count != 0);
        return r;
    endfunction

    task automatic send_item(logic [1:0] md, logic [7:0] dt, logic [15:0] ad);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_mode    <= md;
        s_data    <= dt;
        s_address <= ad;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_blit(md, dt, ad));
        items_sent++;
        @(negedge aclk);
    endtask

    // stream byte; prime any never-written pixel that a shadow draw would read
    task automatic send_byte(logic [7:0] b);
        logic [15:0] a;
        if (phase == 2 && cfg.draw_mode == DRAW_SHADOW && pixel_target(a) && !pixel_set[a])
            send_item(MODE_WRITE, 8'($urandom), a);
        send_item(MODE_STREAM, b, 16'($urandom));
    endtask

    task automatic send_read();
        logic [15:0] a;
        a = set_addrs[$urandom_range(0, set_addrs.size() - 1)];
        send_item(MODE_READ, 8'($urandom), a);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POS_X:       cfg.pos_x = v;
            REG_POS_Y:       cfg.pos_y = v;
            REG_SURF_WIDTH:  cfg.surf_width = v[11:0];
            REG_SURF_HEIGHT: cfg.surf_height = v[11:0];
            REG_ROW_PITCH:   cfg.row_pitch = v[11:0];
            REG_DRAW_MODE:   cfg.draw_mode = v[1:0];
            REG_COLOR_SHIFT: cfg.color_shift = v[4:0];
            default:         cfg.mono_color = v[7:0];
        endcase
    endtask

    task automatic send_header(int w, int h, bit magic);
        if (magic) begin
            send_byte(8'h02); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        end
        send_byte(w[7:0]); send_byte(w[15:8]); send_byte(h[7:0]); send_byte(h[15:8]);
    endtask

    // well-formed body unless noisy; interleave direct accesses at random
    task automatic draw_sprite(int w, int h, bit magic, bit noisy);
        longint left;
        int     lim;
        send_header(w, h, magic);
        while (phase != 0) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1)) send_item(MODE_WRITE, 8'($urandom), 16'($urandom));
                else send_read();
            end
            left = longint'(bmp_w) * bmp_h - pixels_done;
            lim = (left > 127) ? 127 : int'(left);
            if (phase == 2 || noisy) begin
                send_byte(8'($urandom));
            end else if ($urandom_range(0, 2) == 0) begin
                send_byte(SKIP_BASE + 8'($urandom_range(1, (bmp_w < lim) ? bmp_w : lim)));
            end else begin
                send_byte(8'($urandom_range(1, lim)));
            end
        end
    endtask

    task automatic test_direct_access();
        send_item(MODE_WRITE, 8'h00, 16'h0000);
        send_item(MODE_WRITE, 8'hFF, 16'hFFFF);
        send_item(MODE_WRITE, 8'hA5, 16'h5A5A);
        send_item(MODE_READ, 8'hFF, 16'hFFFF);
        send_item(MODE_READ, 8'h00, 16'h0000);
        send_item(MODE_READ, 8'h00, 16'h5A5A);
        send_item(2'd3, 8'hFF, 16'hFFFF);
    endtask

    task automatic test_header_forms();
        send_header(2, 0, 1'b1);
        send_header(0, 5, 1'b0);
        send_byte(8'h02); send_byte(8'h00);
        send_item(2'd3, 8'h12, 16'h0001);
        send_byte(8'h00); send_byte(8'h00);
        send_header(0, 0, 1'b0);
    endtask

    task automatic test_run_overflow();
        send_header(2, 1, 1'b0);
        send_byte(8'h05);
        repeat (5) send_byte(8'($urandom));
    endtask

    task automatic test_draw_modes();
        set_reg(REG_COLOR_SHIFT, 16'h000F);
        draw_sprite(4, 2, 1'b0, 1'b0);
        set_reg(REG_COLOR_SHIFT, 16'h0010);
        set_reg(REG_DRAW_MODE, 16'(DRAW_MONO));
        set_reg(REG_MONO_COLOR, 16'h00FF);
        draw_sprite(4, 2, 1'b0, 1'b0);
        set_reg(REG_DRAW_MODE, 16'(DRAW_SHADOW));
        draw_sprite(4, 2, 1'b1, 1'b0);
        set_reg(REG_DRAW_MODE, 16'd3);
        draw_sprite(3, 1, 1'b0, 1'b0);
    endtask

    task automatic test_clipping();
        set_reg(REG_POS_X, 16'h8000);
        draw_sprite(3, 2, 1'b0, 1'b0);
        set_reg(REG_POS_X, 16'h7FFF);
        set_reg(REG_POS_Y, 16'h8000);
        draw_sprite(3, 2, 1'b0, 1'b0);
        set_reg(REG_POS_X, 16'hFFFE);
        set_reg(REG_POS_Y, 16'hFFFF);
        set_reg(REG_SURF_WIDTH, 16'h0FFF);
        set_reg(REG_SURF_HEIGHT, 16'h0FFF);
        set_reg(REG_ROW_PITCH, 16'h0FFF);
        draw_sprite(200, 2, 1'b0, 1'b0);
        set_reg(REG_SURF_WIDTH, 16'h0000);
        draw_sprite(2, 2, 1'b0, 1'b0);
        set_reg(REG_SURF_WIDTH, 16'd40);
        set_reg(REG_SURF_HEIGHT, 16'h0000);
        set_reg(REG_ROW_PITCH, 16'h0000);
        draw_sprite(2, 2, 1'b0, 1'b0);
    endtask

    task automatic random_reg(logic [2:0] idx, int lo, int hi, logic [15:0] edge_lo,
                              logic [15:0] edge_hi);
        case ($urandom_range(0, 7))
            0:       set_reg(idx, edge_lo);
            1:       set_reg(idx, edge_hi);
            default: set_reg(idx, 16'($urandom_range(lo, hi)));
        endcase
    endtask

    task automatic test_random_traffic();
        while (items_sent < 1150) begin
            burst = ($urandom_range(0, 3) == 0);
            random_reg(REG_POS_X, 0, 24, 16'h8000, 16'h7FFF);
            if (cfg.pos_x < 0 && cfg.pos_x > -32768) set_reg(REG_POS_X, 16'hFFFC);
            random_reg(REG_POS_Y, 0, 12, 16'h8000, 16'h7FFF);
            random_reg(REG_SURF_WIDTH, 8, 64, 16'h0000, 16'h0FFF);
            random_reg(REG_SURF_HEIGHT, 4, 32, 16'h0000, 16'h0FFF);
            random_reg(REG_ROW_PITCH, 16, 200, 16'h0000, 16'h0FFF);
            set_reg(REG_DRAW_MODE, 16'($urandom_range(0, 3)));
            random_reg(REG_COLOR_SHIFT, 0, 31, 16'h0010, 16'h000F);
            random_reg(REG_MONO_COLOR, 0, 255, 16'h0000, 16'h00FF);
            repeat ($urandom_range(1, 3))
                draw_sprite($urandom_range(1, 12), $urandom_range(1, 8), 1'($urandom),
                            $urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 1)) send_item(MODE_WRITE, 8'($urandom), 16'($urandom));
                else send_read();
            end
        end
        burst = 1'b0;
    endtask

    // result checker and sink stalls
    always @(posedge aclk) begin
        blit_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with none expected");
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_read_data !== exp_r.read_data) begin
                    $error("read_data expected %0h actual %0h", exp_r.read_data, m_read_data);
                    errors++;
                end
                if (m_bitmap_done !== exp_r.bitmap_done) begin
                    $error("bitmap_done expected %0b actual %0b", exp_r.bitmap_done,
                           m_bitmap_done);
                    errors++;
                end
                if (m_in_bitmap !== exp_r.in_bitmap) begin
                    $error("in_bitmap expected %0b actual %0b", exp_r.in_bitmap, m_in_bitmap);
                    errors++;
                end
            end
            stall_left = burst ? 0 : $urandom_range(0, 4);
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("rle_sprite_blitter_tb NOT OK");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_mode = '0;
        s_data = '0;
        s_address = '0;
        m_ready = 1'b1;
        errors = 0;
        items_sent = 0;
        idle_cycles = 0;
        stall_left = 0;
        burst = 1'b0;
        cfg = '{pos_x: 0, pos_y: 0, surf_width: SURF_WIDTH_RST,
                surf_height: SURF_HEIGHT_RST, row_pitch: ROW_PITCH_RST,
                draw_mode: 2'd0, color_shift: 5'sd0, mono_color: 8'd0};
        phase = 0; hdr_word = 0; hdr_count = 0; bmp_w = 0; bmp_h = 0;
        col = 0; row = 0; run_left = 0; pixels_done = 0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_direct_access();
        test_header_forms();
        test_run_overflow();
        test_draw_modes();
        test_clipping();
        test_random_traffic();

        drain();
        repeat (20) @(negedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("rle_sprite_blitter_tb OK");
        else
            $display("rle_sprite_blitter_tb NOT OK");
        $finish;
    end

endmodule
